[design/cpfc_pkg.sv]
// ----------------------------------------------------------------------------
// Camera pixel format converter package
// Source codings, output formats and the result pixel type shared by the
// converter core and its pixel generator.
// ----------------------------------------------------------------------------
package cpfc_pkg;

   localparam logic [1:0] SRC_MONO8  = 2'd0;
   localparam logic [1:0] SRC_YUV422 = 2'd1;
   localparam logic [1:0] SRC_RGB8   = 2'd2;
   localparam logic [1:0] SRC_MONO16 = 2'd3;

   localparam logic [1:0] FMT_LUMA = 2'd0;
   localparam logic [1:0] FMT_RGB  = 2'd1;
   localparam logic [1:0] FMT_RGBA = 2'd2;

   localparam logic [1:0] SRC_RESET = SRC_YUV422;
   localparam logic [1:0] FMT_RESET = FMT_RGBA;

   localparam logic [2:0] CNT_NONE = 3'd0;
   localparam logic [2:0] CNT_LUMA = 3'd1;
   localparam logic [2:0] CNT_RGB  = 3'd3;
   localparam logic [2:0] CNT_RGBA = 3'd4;

   localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

   // Register indexes on the configuration port.
   localparam logic REG_SOURCE_CODING = 1'b0;
   localparam logic REG_OUTPUT_FORMAT = 1'b1;

   typedef struct packed {
      logic [7:0] chan0;
      logic [7:0] chan1;
      logic [7:0] chan2;
      logic [7:0] chan3;
      logic [2:0] channel_count;
      logic       last_pixel;
      logic       format_error;
   } pixel_type;

endpackage

[design/cpfc_pixel_gen.sv]
// ----------------------------------------------------------------------------
// Pixel generator
// Builds one output pixel of a held source word: pass-through, YUV luminance,
// BT.601 integer YUV to RGB with rounding and clamping, or an error pixel.
// ----------------------------------------------------------------------------
module cpfc_pixel_gen
   import cpfc_pkg::*;
(
   input  logic [1:0] source_coding,
   input  logic [1:0] output_format,
   input  logic [7:0] byte0,
   input  logic [7:0] byte1,
   input  logic [7:0] byte2,
   input  logic [7:0] byte3,
   input  logic       pixel_index,
   output pixel_type  pixel
);

   logic              err;
   logic              rgba;
   logic [7:0]        luma;
   logic signed [19:0] c_val;
   logic signed [19:0] d_val;
   logic signed [19:0] e_val;
   logic signed [19:0] r_sum;
   logic signed [19:0] g_sum;
   logic signed [19:0] b_sum;
   logic [7:0]        r_out;
   logic [7:0]        g_out;
   logic [7:0]        b_out;

   function automatic logic [7:0] clamp_shift(input logic signed [19:0] sum);
      logic [7:0] res;
      if (sum[19]) begin
         res = 8'd0;
      end else if (sum[18:16] != 3'd0) begin
         res = 8'd255;
      end else begin
         res = sum[15:8];
      end
      return res;
   endfunction

   always_comb begin
      case (source_coding)
         SRC_MONO8, SRC_MONO16: err = (output_format != FMT_LUMA);
         SRC_RGB8:              err = (output_format != FMT_RGB) &&
                                      (output_format != FMT_RGBA);
         SRC_YUV422:            err = (output_format != FMT_LUMA) &&
                                      (output_format != FMT_RGB) &&
                                      (output_format != FMT_RGBA);
         default:               err = 1'b1;
      endcase
   end

   assign rgba = (output_format == FMT_RGBA);
   assign luma = pixel_index ? byte3 : byte1;

   assign c_val = $signed({12'd0, luma})  - 20'sd16;
   assign d_val = $signed({12'd0, byte0}) - 20'sd128;
   assign e_val = $signed({12'd0, byte2}) - 20'sd128;

   assign r_sum = c_val * 20'sd298 + e_val * 20'sd409 + 20'sd128;
   assign g_sum = c_val * 20'sd298 - d_val * 20'sd100 - e_val * 20'sd208 + 20'sd128;
   assign b_sum = c_val * 20'sd298 + d_val * 20'sd516 + 20'sd128;

   assign r_out = clamp_shift(r_sum);
   assign g_out = clamp_shift(g_sum);
   assign b_out = clamp_shift(b_sum);

   always_comb begin
      pixel = '0;
      pixel.last_pixel = 1'b1;
      if (err) begin
         pixel.format_error = 1'b1;
         pixel.channel_count = CNT_NONE;
      end else begin
         case (source_coding)
            SRC_MONO8, SRC_MONO16: begin
               pixel.chan0 = byte0;
               pixel.channel_count = CNT_LUMA;
            end
            SRC_RGB8: begin
               pixel.chan0 = byte0;
               pixel.chan1 = byte1;
               pixel.chan2 = byte2;
               pixel.chan3 = rgba ? ALPHA_OPAQUE : 8'd0;
               pixel.channel_count = rgba ? CNT_RGBA : CNT_RGB;
            end
            default: begin
               // YUV gives two pixels; the second one closes the word.
               pixel.last_pixel = pixel_index;
               if (output_format == FMT_LUMA) begin
                  pixel.chan0 = luma;
                  pixel.channel_count = CNT_LUMA;
               end else begin
                  pixel.chan0 = r_out;
                  pixel.chan1 = g_out;
                  pixel.chan2 = b_out;
                  pixel.chan3 = rgba ? ALPHA_OPAQUE : 8'd0;
                  pixel.channel_count = rgba ? CNT_RGBA : CNT_RGB;
               end
            end
         endcase
      end
   end

endmodule

[design/camera_pixel_format_converter_core.sv]
// ----------------------------------------------------------------------------
// Camera pixel format converter core
// Turns four-byte camera source words into display pixels.
// ----------------------------------------------------------------------------
// Usage:
// A source word (req_byte0..3) is taken on the req channel when req_valid is
// high and req_stall is low. Pixels leave on the rsp channel, one per word
// transfer, with rsp_last_pixel marking the final pixel of a source word.
// A YUV 4:2:2 word gives two pixels, every other case one pixel; an
// unsupported coding/format pair gives one pixel with rsp_format_error set.
// A word reaches rsp through the input and result registers. Throughput is
// one word per cycle for single-pixel modes while rsp does not stall; a YUV
// word leaves only as its second pixel moves on. When the receiver stalls,
// the result register holds its pixel and the input register keeps its word,
// so req_stall rises until rsp moves again. Configuration sits on an
// APB-style port: source_coding at 0x0 and output_format at 0x4; the user
// writes it only while the block is idle; the block does not enforce this.
// Synchronous reset empties both registers and loads YUV 4:2:2 to RGBA.
// ----------------------------------------------------------------------------
module camera_pixel_format_converter_core
   import cpfc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte0,
   input  logic [7:0]  req_byte1,
   input  logic [7:0]  req_byte2,
   input  logic [7:0]  req_byte3,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_chan0,
   output logic [7:0]  rsp_chan1,
   output logic [7:0]  rsp_chan2,
   output logic [7:0]  rsp_chan3,
   output logic [2:0]  rsp_channel_count,
   output logic        rsp_last_pixel,
   output logic        rsp_format_error,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [1:0] src_ff, src_in;
   logic [1:0] fmt_ff, fmt_in;
   logic       hold_valid_ff, hold_valid_in;
   logic       idx_ff, idx_in;
   logic [7:0] b0_ff, b0_in;
   logic [7:0] b1_ff, b1_in;
   logic [7:0] b2_ff, b2_in;
   logic [7:0] b3_ff, b3_in;
   logic       rsp_valid_ff, rsp_valid_in;
   pixel_type  pix_ff, pix_in;
   pixel_type  gen_pixel;
   logic       cfg_write;
   logic       take;
   logic       advance;
   logic       done;

   cpfc_pixel_gen u_pixel_gen (
      .source_coding (src_ff),
      .output_format (fmt_ff),
      .byte0         (b0_ff),
      .byte1         (b1_ff),
      .byte2         (b2_ff),
      .byte3         (b3_ff),
      .pixel_index   (idx_ff),
      .pixel         (gen_pixel)
   );

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_OUTPUT_FORMAT) ? {30'd0, fmt_ff} : {30'd0, src_ff};

   // The generator advances whenever a word is held and the result register is free or draining.
   assign advance   = hold_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign done      = advance && gen_pixel.last_pixel;
   assign req_stall = hold_valid_ff && !done;
   assign take      = req_valid && !req_stall;

   always_comb begin
      src_in = src_ff;
      fmt_in = fmt_ff;
      if (cfg_write) begin
         if (paddr[2] == REG_SOURCE_CODING) begin
            src_in = pwdata[1:0];
         end else begin
            fmt_in = pwdata[1:0];
         end
      end

      hold_valid_in = hold_valid_ff;
      idx_in = idx_ff;
      b0_in = b0_ff;
      b1_in = b1_ff;
      b2_in = b2_ff;
      b3_in = b3_ff;
      if (take) begin
         hold_valid_in = 1'b1;
         idx_in = 1'b0;
         b0_in = req_byte0;
         b1_in = req_byte1;
         b2_in = req_byte2;
         b3_in = req_byte3;
      end else if (done) begin
         hold_valid_in = 1'b0;
      end else if (advance) begin
         idx_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      pix_in = pix_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         pix_in = gen_pixel;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= SRC_RESET;
         fmt_ff <= FMT_RESET;
         hold_valid_ff <= 1'b0;
         idx_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         src_ff <= src_in;
         fmt_ff <= fmt_in;
         hold_valid_ff <= hold_valid_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      b0_ff <= b0_in;
      b1_ff <= b1_in;
      b2_ff <= b2_in;
      b3_ff <= b3_in;
      pix_ff <= pix_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chan0         = pix_ff.chan0;
   assign rsp_chan1         = pix_ff.chan1;
   assign rsp_chan2         = pix_ff.chan2;
   assign rsp_chan3         = pix_ff.chan3;
   assign rsp_channel_count = pix_ff.channel_count;
   assign rsp_last_pixel    = pix_ff.last_pixel;
   assign rsp_format_error  = pix_ff.format_error;

`ifndef SYNTH
   // The second pixel of a word only exists in YUV mode.
   a_second_pixel_yuv: assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && idx_ff) |-> (src_ff == SRC_YUV422))
      else $error("second pixel outside YUV mode");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && pix_ff.format_error) |->
      (pix_ff.last_pixel && (pix_ff.channel_count == CNT_NONE)))
      else $error("error pixel is malformed");

   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      take |=> (hold_valid_ff && !idx_ff))
      else $error("accepted word not held at pixel zero");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !hold_valid_ff |-> !req_stall)
      else $error("stall while input register is empty");

   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      (advance && !idx_ff && !gen_pixel.format_error && (src_ff == SRC_YUV422)) |->
      !gen_pixel.last_pixel)
      else $error("first YUV pixel flagged as last");
`endif

endmodule

[dv/camera_pixel_format_converter_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Camera pixel format converter core testbench
// Programs each source coding and output format through the register port,
// reads every setting back, sends a table of hand-picked source words and
// then random words under random sender gaps and receiver stalls. Every
// pixel that leaves the core is compared field by field with the table's
// expected pixel or a BT.601 conversion model kept inside this bench.
// ----------------------------------------------------------------------------
module camera_pixel_format_converter_core_tb;
   import cpfc_pkg::*;

   localparam int DRAIN_CYCLES   = 4;
   localparam int PHASE_COUNT    = 12;
   localparam int WORDS_PER_PHASE = 32;
   localparam int PRINT_LIMIT    = 40;

   localparam pixel_type NO_PIXEL    = '0;
   localparam pixel_type ERROR_PIXEL = '{8'd0, 8'd0, 8'd0, 8'd0, CNT_NONE, 1'b1, 1'b1};

   typedef enum int {RX_READY, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_type;

   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
   } source_word_type;

   typedef struct packed {
      logic [1:0]      src;
      logic [1:0]      fmt;
      source_word_type word;
      logic            typed;
      pixel_type       want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_byte0;
   logic [7:0]  req_byte1;
   logic [7:0]  req_byte2;
   logic [7:0]  req_byte3;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_chan0;
   logic [7:0]  rsp_chan1;
   logic [7:0]  rsp_chan2;
   logic [7:0]  rsp_chan3;
   logic [2:0]  rsp_channel_count;
   logic        rsp_last_pixel;
   logic        rsp_format_error;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   pixel_type      expected_pixels[$];
   logic [1:0]     model_source;
   logic [1:0]     model_format;
   int             error_count = 0;
   int             pixels_checked = 0;
   int             hold_off_left = 0;
   int             rx_phase = 0;
   rx_pattern_type rx_pattern = RX_READY;

   // Hand-picked words, grouped so that each register setting is programmed at most once.
   directed_row_type directed_rows [22] = '{
      '{SRC_YUV422, FMT_RGBA, '{8'd128, 8'd16, 8'd128, 8'd235}, 1'b0, NO_PIXEL},
      '{SRC_YUV422, FMT_RGBA, '{8'd0, 8'd255, 8'd255, 8'd0}, 1'b0, NO_PIXEL},
      '{SRC_YUV422, FMT_RGBA, '{8'd255, 8'd0, 8'd0, 8'd255}, 1'b0, NO_PIXEL},
      '{SRC_YUV422, FMT_RGB, '{8'd90, 8'd81, 8'd240, 8'd41}, 1'b0, NO_PIXEL},
      '{SRC_YUV422, FMT_RGB, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b0, NO_PIXEL},
      '{SRC_YUV422, FMT_LUMA, '{8'd0, 8'd255, 8'd0, 8'd0}, 1'b0, NO_PIXEL},
      '{SRC_YUV422, FMT_LUMA, '{8'd255, 8'd0, 8'd255, 8'd255}, 1'b0, NO_PIXEL},
      '{SRC_YUV422, 2'd3, '{8'd1, 8'd2, 8'd3, 8'd4}, 1'b1, ERROR_PIXEL},
      '{SRC_MONO8, FMT_LUMA, '{8'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
        '{8'd0, 8'd0, 8'd0, 8'd0, CNT_LUMA, 1'b1, 1'b0}},
      '{SRC_MONO8, FMT_LUMA, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
        '{8'd255, 8'd0, 8'd0, 8'd0, CNT_LUMA, 1'b1, 1'b0}},
      '{SRC_MONO8, FMT_RGB, '{8'd5, 8'd6, 8'd7, 8'd8}, 1'b1, ERROR_PIXEL},
      '{SRC_MONO8, FMT_RGBA, '{8'd255, 8'd0, 8'd255, 8'd0}, 1'b1, ERROR_PIXEL},
      '{SRC_MONO8, 2'd3, '{8'd9, 8'd10, 8'd11, 8'd12}, 1'b1, ERROR_PIXEL},
      '{SRC_RGB8, FMT_LUMA, '{8'd13, 8'd14, 8'd15, 8'd16}, 1'b1, ERROR_PIXEL},
      '{SRC_RGB8, FMT_RGB, '{8'd255, 8'd0, 8'd170, 8'd85}, 1'b1,
        '{8'd255, 8'd0, 8'd170, 8'd0, CNT_RGB, 1'b1, 1'b0}},
      '{SRC_RGB8, FMT_RGBA, '{8'd0, 8'd255, 8'd85, 8'd170}, 1'b1,
        '{8'd0, 8'd255, 8'd85, ALPHA_OPAQUE, CNT_RGBA, 1'b1, 1'b0}},
      '{SRC_RGB8, 2'd3, '{8'd17, 8'd18, 8'd19, 8'd20}, 1'b1, ERROR_PIXEL},
      '{SRC_MONO16, FMT_LUMA, '{8'd18, 8'd52, 8'd86, 8'd120}, 1'b1,
        '{8'd18, 8'd0, 8'd0, 8'd0, CNT_LUMA, 1'b1, 1'b0}},
      '{SRC_MONO16, FMT_LUMA, '{8'd255, 8'd0, 8'd0, 8'd0}, 1'b1,
        '{8'd255, 8'd0, 8'd0, 8'd0, CNT_LUMA, 1'b1, 1'b0}},
      '{SRC_MONO16, FMT_RGB, '{8'd21, 8'd22, 8'd23, 8'd24}, 1'b1, ERROR_PIXEL},
      '{SRC_MONO16, FMT_RGBA, '{8'd25, 8'd26, 8'd27, 8'd28}, 1'b1, ERROR_PIXEL},
      '{SRC_MONO16, 2'd3, '{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, ERROR_PIXEL}
   };

   camera_pixel_format_converter_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_byte0         (req_byte0),
      .req_byte1         (req_byte1),
      .req_byte2         (req_byte2),
      .req_byte3         (req_byte3),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_chan0         (rsp_chan0),
      .rsp_chan1         (rsp_chan1),
      .rsp_chan2         (rsp_chan2),
      .rsp_chan3         (rsp_chan3),
      .rsp_channel_count (rsp_channel_count),
      .rsp_last_pixel    (rsp_last_pixel),
      .rsp_format_error  (rsp_format_error),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("MISMATCH %s at pixel %0d: got %0d, expected %0d",
                  what, pixels_checked, got, want);
      end
   endtask

   // Negative sums clamp to zero before the shift, as the floor would.
   function automatic logic [7:0] bt601_clamp(input int sum);
      if (sum < 0) begin
         return 8'd0;
      end
      if ((sum >>> 8) > 255) begin
         return 8'd255;
      end
      return 8'(sum >>> 8);
   endfunction

   function automatic pixel_type yuv_to_pixel(input logic [7:0] y, input logic [7:0] u,
                                              input logic [7:0] v, input logic last);
      int        c;
      int        d;
      int        e;
      logic      rgba;
      pixel_type p;
      c = int'(y) - 16;
      d = int'(u) - 128;
      e = int'(v) - 128;
      rgba = (model_format == FMT_RGBA);
      p.chan0 = bt601_clamp(298 * c + 409 * e + 128);
      p.chan1 = bt601_clamp(298 * c - 100 * d - 208 * e + 128);
      p.chan2 = bt601_clamp(298 * c + 516 * d + 128);
      p.chan3 = rgba ? ALPHA_OPAQUE : 8'd0;
      p.channel_count = rgba ? CNT_RGBA : CNT_RGB;
      p.last_pixel = last;
      p.format_error = 1'b0;
      return p;
   endfunction

   function automatic void queue_chunk_pixels(input source_word_type w);
      pixel_type p;
      p = ERROR_PIXEL;
      case (model_source)
         SRC_MONO8, SRC_MONO16: begin
            if (model_format == FMT_LUMA) begin
               p = '{w.b0, 8'd0, 8'd0, 8'd0, CNT_LUMA, 1'b1, 1'b0};
            end
         end
         SRC_RGB8: begin
            if (model_format == FMT_RGB) begin
               p = '{w.b0, w.b1, w.b2, 8'd0, CNT_RGB, 1'b1, 1'b0};
            end else if (model_format == FMT_RGBA) begin
               p = '{w.b0, w.b1, w.b2, ALPHA_OPAQUE, CNT_RGBA, 1'b1, 1'b0};
            end
         end
         default: begin
            if (model_format == FMT_LUMA) begin
               expected_pixels.push_back('{w.b1, 8'd0, 8'd0, 8'd0, CNT_LUMA, 1'b0, 1'b0});
               expected_pixels.push_back('{w.b3, 8'd0, 8'd0, 8'd0, CNT_LUMA, 1'b1, 1'b0});
               return;
            end
            if (model_format == FMT_RGB || model_format == FMT_RGBA) begin
               expected_pixels.push_back(yuv_to_pixel(w.b1, w.b0, w.b2, 1'b0));
               expected_pixels.push_back(yuv_to_pixel(w.b3, w.b0, w.b2, 1'b1));
               return;
            end
         end
      endcase
      expected_pixels.push_back(p);
   endfunction

   // Called at a rising edge; returns at the edge where the word is taken.
   task automatic send_word(input source_word_type w, input logic typed,
                            input pixel_type want);
      req_valid <= 1'b1;
      req_byte0 <= w.b0;
      req_byte1 <= w.b1;
      req_byte2 <= w.b2;
      req_byte3 <= w.b3;
      do @(posedge clock); while (req_stall);
      if (typed) begin
         expected_pixels.push_back(want);
      end else begin
         queue_chunk_pixels(w);
      end
   endtask

   task automatic wait_for_drain();
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes one register with junk in the unused upper bits, then reads it back.
   task automatic program_register(input logic idx, input logic [1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= ($urandom() & ~32'h3) | 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == REG_SOURCE_CODING) begin
         model_source = value;
      end else begin
         model_format = value;
      end
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== 32'(value)) begin
         report_mismatch(idx == REG_SOURCE_CODING ? "source_coding readback"
                                                  : "output_format readback",
                         prdata, value);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd16;
         3: return 8'd235;
         4: return 8'd128;
         default: return 8'($urandom());
      endcase
   endfunction

   // Receiver: a long hold-off when one is requested, otherwise the phase pattern.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (rx_pattern)
               RX_READY:    rsp_stall <= 1'b0;
               RX_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
               RX_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 7);
               RX_PERIODIC: begin
                  rx_phase++;
                  rsp_stall <= (rx_phase % 5 < 2);
               end
               default:     rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("pixel with none expected", rsp_chan0, 0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_chan0 !== want.chan0) report_mismatch("chan0", rsp_chan0, want.chan0);
            if (rsp_chan1 !== want.chan1) report_mismatch("chan1", rsp_chan1, want.chan1);
            if (rsp_chan2 !== want.chan2) report_mismatch("chan2", rsp_chan2, want.chan2);
            if (rsp_chan3 !== want.chan3) report_mismatch("chan3", rsp_chan3, want.chan3);
            if (rsp_channel_count !== want.channel_count) begin
               report_mismatch("channel_count", rsp_channel_count, want.channel_count);
            end
            if (rsp_last_pixel !== want.last_pixel) begin
               report_mismatch("last_pixel", rsp_last_pixel, want.last_pixel);
            end
            if (rsp_format_error !== want.format_error) begin
               report_mismatch("format_error", rsp_format_error, want.format_error);
            end
         end
         pixels_checked++;
      end
   end

   initial begin
      source_word_type word;
      logic [1:0]      src;
      logic [1:0]      fmt;
      logic            sender_idle;
      int              burst_left;
      int              gap;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_byte0 = 8'd0;
      req_byte1 = 8'd0;
      req_byte2 = 8'd0;
      req_byte3 = 8'd0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = 3'd0;
      pwdata    = 32'd0;
      model_source = SRC_RESET;
      model_format = FMT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first rows run on the reset setting, with no register written.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].src != model_source || directed_rows[i].fmt != model_format) begin
            req_valid <= 1'b0;
            wait_for_drain();
            program_register(REG_SOURCE_CODING, directed_rows[i].src);
            program_register(REG_OUTPUT_FORMAT, directed_rows[i].fmt);
         end
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
      end
      req_valid <= 1'b0;
      wait_for_drain();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: begin src = SRC_YUV422; fmt = FMT_RGBA; end
            1: begin src = SRC_YUV422; fmt = FMT_RGB;  end
            2: begin src = SRC_YUV422; fmt = FMT_LUMA; end
            3: begin src = SRC_MONO8;  fmt = FMT_LUMA; end
            4: begin src = SRC_RGB8;   fmt = FMT_RGB;  end
            5: begin src = SRC_RGB8;   fmt = FMT_RGBA; end
            6: begin src = SRC_MONO16; fmt = FMT_LUMA; end
            7: begin src = SRC_YUV422; fmt = FMT_RGBA; end
            default: begin
               src = 2'($urandom_range(0, 3));
               fmt = 2'($urandom_range(0, 3));
            end
         endcase
         program_register(REG_SOURCE_CODING, src);
         program_register(REG_OUTPUT_FORMAT, fmt);
         rx_pattern = rx_pattern_type'(ph % 4);
         sender_idle = (ph % 3 != 1);
         // The receiver holds off while the sender keeps offering words.
         if (ph == 1 || ph == 7) begin
            hold_off_left = 80;
         end
         burst_left = 0;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               gap = sender_idle ? $urandom_range(0, 6) : 0;
               if (gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
               burst_left = $urandom_range(1, 12);
            end
            word = '{pick_byte(), pick_byte(), pick_byte(), pick_byte()};
            send_word(word, 1'b0, NO_PIXEL);
            burst_left--;
         end
         req_valid <= 1'b0;
         wait_for_drain();
      end

      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
